/* hdl/olidd_pkg.sv */
// Shared types, widths and codes for the ordered list unit.
`default_nettype none
package olidd_pkg;

  localparam int ACTION_W       = 2;
  localparam int IN_VALUE_W     = 32;
  localparam int POS_W          = 6;
  localparam int ELEM_W         = 32;
  localparam int INDEX_W        = 6;
  localparam int IN_TDATA_W     = 40;
  localparam int OUT_TDATA_W    = 40;
  localparam int OUT_TUSER_W    = 2;
  localparam int CAPACITY_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_FRONT  = 2'd0,
    ACT_BACK   = 2'd1,
    ACT_DELETE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    MODE_COPY,
    MODE_INS,
    MODE_DEL
  } mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } ctl_state_t;

  typedef struct packed {
    logic start;
    logic fetch;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic more;
    logic adv;
    logic last_taken;
  } dp_stat_t;

endpackage
`default_nettype wire

/* hdl/olidd_ctrl.sv */
// Controller state machine that sequences the update and dump of one item.
`default_nettype none
module olidd_ctrl
  import olidd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.start  = 1'b0;
    cmd.fetch  = 1'b0;
    cmd.finish = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_DUMP;
        end
      end
      ST_DUMP: begin
        cmd.fetch = stat.more && stat.adv;
        if (stat.last_taken) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/olidd_dpath.sv */
// Datapath with the two-bank list memory, update decode and output register.
`default_nettype none
module olidd_dpath
  import olidd_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dp_cmd_t               cmd,
  output dp_stat_t                   stat,
  input  wire logic [ACTION_W-1:0]   in_action,
  input  wire logic [IN_VALUE_W-1:0] in_value,
  input  wire logic [POS_W-1:0]      in_position,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [ELEM_W-1:0]          out_element,
  output logic [INDEX_W-1:0]         out_index,
  output logic                       out_last,
  output logic                       out_empty,
  output logic                       out_dropped
);

  localparam int LEN_W     = $clog2(CAPACITY + 1);
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CMP_W     = (LEN_W > POS_W) ? LEN_W : POS_W;
  localparam int MEM_DEPTH = 2 * (1 << ADDR_W);

  logic [VALUE_BITS-1:0] mem [MEM_DEPTH];

  logic                  bank_r;
  logic [LEN_W-1:0]      len_r;
  logic [LEN_W-1:0]      n_new_r, n_new_nxt;
  logic [LEN_W-1:0]      cnt_r;
  logic [LEN_W-1:0]      j_r;
  mode_t                 mode_r, mode_nxt;
  logic [ADDR_W-1:0]     ins_at_r, ins_at_nxt;
  logic [ADDR_W-1:0]     del_pos_r;
  logic [VALUE_BITS-1:0] val_r;
  logic                  drop_r, drop_nxt;
  logic                  empty_r;
  logic [VALUE_BITS-1:0] rdata_r;
  logic                  sel_val_r;
  logic [ADDR_W-1:0]     out_idx_r;
  logic                  out_last_r;
  logic                  out_valid_r;

  logic                  full;
  logic [ADDR_W-1:0]     jj;
  logic [ADDR_W-1:0]     src_addr;
  logic [VALUE_BITS-1:0] elem_w;
  logic                  take;

  assign full = (len_r == LEN_W'(CAPACITY));
  assign jj   = j_r[ADDR_W-1:0];
  assign take = out_valid_r && out_ready;

  always_comb begin
    n_new_nxt  = len_r;
    mode_nxt   = MODE_COPY;
    ins_at_nxt = '0;
    drop_nxt   = 1'b0;
    case (in_action)
      ACT_FRONT, ACT_BACK: begin
        if (full) begin
          drop_nxt = 1'b1;
        end else begin
          mode_nxt   = MODE_INS;
          n_new_nxt  = len_r + LEN_W'(1);
          ins_at_nxt = (in_action == ACT_FRONT) ? '0 : len_r[ADDR_W-1:0];
        end
      end
      ACT_DELETE: begin
        if (CMP_W'(in_position) < CMP_W'(len_r)) begin
          mode_nxt  = MODE_DEL;
          n_new_nxt = len_r - LEN_W'(1);
        end
      end
      default: begin
        mode_nxt = MODE_COPY;
      end
    endcase
  end

  always_comb begin
    case (mode_r)
      MODE_INS: src_addr = (jj > ins_at_r) ? jj - ADDR_W'(1) : jj;
      MODE_DEL: src_addr = (jj >= del_pos_r) ? jj + ADDR_W'(1) : jj;
      default:  src_addr = jj;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
      j_r         <= '0;
    end else begin
      if (cmd.start) begin
        j_r <= '0;
      end else if (cmd.fetch) begin
        j_r <= j_r + LEN_W'(1);
      end
      if (cmd.fetch) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.finish) begin
        len_r  <= n_new_r;
        bank_r <= ~bank_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n_new_r   <= n_new_nxt;
      cnt_r     <= (n_new_nxt == '0) ? LEN_W'(1) : n_new_nxt;
      empty_r   <= (n_new_nxt == '0);
      mode_r    <= mode_nxt;
      ins_at_r  <= ins_at_nxt;
      del_pos_r <= ADDR_W'(in_position);
      val_r     <= VALUE_BITS'($signed(in_value));
      drop_r    <= drop_nxt;
    end
    if (cmd.fetch) begin
      sel_val_r  <= (mode_r == MODE_INS) && (jj == ins_at_r);
      out_idx_r  <= jj;
      out_last_r <= (j_r == cnt_r - LEN_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rdata_r <= mem[{bank_r, src_addr}];
    end
  end

  assign elem_w = sel_val_r ? val_r : rdata_r;

  always_ff @(posedge clk) begin
    if (take && !empty_r) begin
      mem[{~bank_r, out_idx_r}] <= elem_w;
    end
  end

  assign stat.more       = (j_r < cnt_r);
  assign stat.adv        = !out_valid_r || out_ready;
  assign stat.last_taken = take && out_last_r;

  assign out_valid   = out_valid_r;
  assign out_element = empty_r ? '0 : ELEM_W'($signed(elem_w));
  assign out_index   = INDEX_W'(out_idx_r);
  assign out_last    = out_last_r;
  assign out_empty   = empty_r;
  assign out_dropped = drop_r;

endmodule
`default_nettype wire

/* hdl/ordered_list_insert_delete_dump_unit.sv */
// Top level of the ordered list unit: item in, list update, dump of the whole list out.
// An item whose update leaves n elements yields max(n, 1) result items, one per cycle
// while the output is not stalled. The first result is valid once the controller is in
// its dump state and the first element is in the output register. No new item is
// taken until the last result is taken. The list memory has a single read port.
// Reset clears the length and the bank select; memory contents are not cleared.
`default_nettype none
module ordered_list_insert_delete_dump_unit
  import olidd_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // action, value, position
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // element, index, zero fill
  output logic                        out_tlast,
  output logic [OUT_TUSER_W-1:0]      out_tuser   // empty_res, dropped
);

  localparam int OUT_PAD_W = OUT_TDATA_W - ELEM_W - INDEX_W;

  dp_cmd_t              cmd;
  dp_stat_t             stat;
  logic [ELEM_W-1:0]    element;
  logic [INDEX_W-1:0]   index;
  logic                 empty_res;
  logic                 dropped;

  olidd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  olidd_dpath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_action   (in_tdata[ACTION_W-1:0]),
    .in_value    (in_tdata[ACTION_W +: IN_VALUE_W]),
    .in_position (in_tdata[ACTION_W+IN_VALUE_W +: POS_W]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_element (element),
    .out_index   (index),
    .out_last    (out_tlast),
    .out_empty   (empty_res),
    .out_dropped (dropped)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, index, element};
  assign out_tuser = {dropped, empty_res};

  a_idle_no_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("result pending while taking a new item");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready)
    else $error("unit did not return to idle after the last result");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("unit took two items back to back");

  a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && (index == '0) && (element == '0))
    else $error("empty list result is not a single zero item");

endmodule
`default_nettype wire

/* tb/sv/ordered_list_insert_delete_dump_unit_test.sv */
// Self-checking testbench for the ordered list unit: random commands, stalls and a list predictor.
`timescale 1ns / 1ps
module ordered_list_insert_delete_dump_unit_test;
  import olidd_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int RANDOM_ITEMS = 310;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef enum int {
    BURST_FILL,
    BURST_GROW,
    BURST_SHRINK,
    BURST_MIX
  } burst_kind_t;

  typedef struct packed {
    logic [ELEM_W-1:0]  element;
    logic [INDEX_W-1:0] index;
    logic               last;
    logic               empty_res;
    logic               dropped;
  } dump_entry_t;

  class list_scoreboard;
    logic [ELEM_W-1:0] cells[$];
    dump_entry_t       dump_due[$];
    int                errors;

    function new();
      errors = 0;
    endfunction

    function int depth();
      return cells.size();
    endfunction

    function int pending();
      return dump_due.size();
    endfunction

    function void note_item(logic [ACTION_W-1:0] act, logic [IN_VALUE_W-1:0] val,
                            logic [POS_W-1:0] pos);
      logic        refused;
      dump_entry_t e;
      refused = 1'b0;
      case (act)
        ACT_FRONT, ACT_BACK: begin
          if (cells.size() >= CAPACITY) refused = 1'b1;
          else if (act == ACT_FRONT) cells.push_front(val);
          else cells.push_back(val);
        end
        ACT_DELETE: begin
          if (pos < cells.size()) cells.delete(pos);
        end
        default: ;
      endcase
      if (cells.size() == 0) begin
        e = '{element: '0, index: '0, last: 1'b1, empty_res: 1'b1, dropped: refused};
        dump_due.push_back(e);
      end else begin
        for (int i = 0; i < cells.size(); i++) begin
          e.element   = cells[i];
          e.index     = INDEX_W'(i);
          e.last      = (i == cells.size() - 1);
          e.empty_res = 1'b0;
          e.dropped   = refused;
          dump_due.push_back(e);
        end
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_result(dump_entry_t got);
      dump_entry_t want;
      if (dump_due.size() == 0) begin
        report($sformatf("unexpected item, element %0d index %0d",
                         $signed(got.element), got.index));
      end else begin
        want = dump_due.pop_front();
        if (got.element !== want.element)
          report($sformatf("element %0d, predicted %0d", $signed(got.element),
                           $signed(want.element)));
        if (got.index !== want.index)
          report($sformatf("index %0d, predicted %0d", got.index, want.index));
        if (got.last !== want.last)
          report($sformatf("last %b, predicted %b", got.last, want.last));
        if (got.empty_res !== want.empty_res)
          report($sformatf("empty %b, predicted %b", got.empty_res, want.empty_res));
        if (got.dropped !== want.dropped)
          report($sformatf("dropped %b, predicted %b", got.dropped, want.dropped));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic [OUT_TUSER_W-1:0] out_tuser;

  list_scoreboard sb = new();
  bit             no_idle = 1'b0;
  int             cycles = 0;
  int             stall_left = 0;

  ordered_list_insert_delete_dump_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pick_pause();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_gap();
    if (no_idle || $urandom_range(0, 99) < 65) return 0;
    return pick_pause();
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result('{element: out_tdata[ELEM_W-1:0],
                        index: out_tdata[ELEM_W +: INDEX_W],
                        last: out_tlast, empty_res: out_tuser[0], dropped: out_tuser[1]});
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else if (rst_n && !no_idle && $urandom_range(0, 99) < 25) begin
      stall_left = pick_pause() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_item(logic [ACTION_W-1:0] act, logic [IN_VALUE_W-1:0] val,
                           logic [POS_W-1:0] pos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pos, val, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(act, val, pos);
  endtask

  task automatic send_random(burst_kind_t kind);
    int                  r;
    logic [ACTION_W-1:0] act;
    logic [POS_W-1:0]    pos;
    r   = $urandom_range(0, 99);
    pos = POS_W'($urandom_range(0, 63));
    if (sb.depth() > 0 && $urandom_range(0, 1) == 1)
      pos = POS_W'($urandom_range(0, sb.depth() - 1));
    case (kind)
      BURST_FILL: act = (r < 50) ? ACT_FRONT : ACT_BACK;
      BURST_GROW: act = (r < 45) ? ACT_FRONT : (r < 90) ? ACT_BACK : ACT_DELETE;
      BURST_SHRINK: begin
        act = (r < 85) ? ACT_DELETE : (r < 95) ? ACT_BACK : ACT_FRONT;
        if (r < 75 && sb.depth() > 0) pos = POS_W'($urandom_range(0, sb.depth() - 1));
      end
      default: act = ACTION_W'($urandom_range(0, 3));
    endcase
    send_item(act, $urandom, pos);
  endtask

  initial begin
    int          sent;
    int          burst_len;
    burst_kind_t kind;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list, unused code, extremes of the value, deletes in and out of range.
    send_item(ACT_DELETE, 32'd0, 6'd0);
    send_item(ACT_UNUSED, 32'hFFFF_FFFF, 6'd63);
    send_item(ACT_FRONT, 32'h7FFF_FFFF, 6'd0);
    send_item(ACT_BACK, 32'h8000_0000, 6'd63);
    send_item(ACT_FRONT, 32'hFFFF_FFFF, 6'd0);
    send_item(ACT_BACK, 32'h0000_0000, 6'd0);
    send_item(ACT_FRONT, 32'h0000_0001, 6'd0);
    send_item(ACT_DELETE, 32'd0, 6'd63);
    send_item(ACT_DELETE, 32'd0, 6'd5);
    send_item(ACT_DELETE, 32'd0, 6'd4);
    send_item(ACT_DELETE, 32'd0, 6'd0);
    send_item(ACT_UNUSED, 32'h1234_5678, 6'd1);
    send_item(ACT_DELETE, 32'd0, 6'd1);
    send_item(ACT_DELETE, 32'd0, 6'd1);
    send_item(ACT_DELETE, 32'd0, 6'd0);
    send_item(ACT_DELETE, 32'd0, 6'd0);

    // The first burst only inserts, so the list fills up and later inserts are refused.
    sent = 0;
    kind = BURST_FILL;
    burst_len = CAPACITY + 6;
    while (sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < burst_len && sent < RANDOM_ITEMS; i++) begin
        send_random(kind);
        sent++;
      end
      kind = burst_kind_t'($urandom_range(0, 3));
      burst_len = $urandom_range(10, 45);
    end
    in_tvalid <= 1'b0;
    no_idle = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
